// File: rtl/lrlsc_pkg.sv
// Package for the line run-length signal classifier.
// Holds default widths, classification limits, class codes and shared types.
// No dependencies.
package lrlsc_pkg;

   localparam int COUNTER_WIDTH_DEF = 32;
   localparam int RUN_WIDTH_DEF     = 16;

   localparam int STUCK_LIMIT     = 1000;
   localparam int MIN_TRANSITIONS = 20;
   localparam int SHORT_LIMIT     = 2;
   localparam int MEDIUM_LIMIT    = 5;
   localparam int LONG_LIMIT      = 12;

   localparam int KIND_WIDTH = 3;

   typedef logic [KIND_WIDTH-1:0] kind_type;

   localparam kind_type KIND_UNKNOWN    = 3'd0;
   localparam kind_type KIND_STUCK_HIGH = 3'd1;
   localparam kind_type KIND_STUCK_LOW  = 3'd2;
   localparam kind_type KIND_MANCHESTER = 3'd3;
   localparam kind_type KIND_SERIAL     = 3'd4;

   // Control from the sample stage into the statistics block
   typedef struct packed {
      logic step;
      logic level;
   } stats_ctl_type;

endpackage

// File: rtl/lrlsc_if.sv
// Channel interfaces of the line run-length signal classifier.
// Sample, result and register write channels, valid/ready handshake.
// Depends on lrlsc_pkg.
interface lrlsc_req_if;
   logic valid;
   logic ready;
   logic raw_sample;

   modport source  (output valid, output raw_sample, input ready);
   modport sink    (input valid, input raw_sample, output ready);
   modport monitor (input valid, input raw_sample, input ready);
endinterface

interface lrlsc_rsp_if import lrlsc_pkg::*;;
   logic     valid;
   logic     ready;
   logic     bus_level;
   kind_type signal_kind;

   modport source  (output valid, output bus_level, output signal_kind, input ready);
   modport sink    (input valid, input bus_level, input signal_kind, output ready);
   modport monitor (input valid, input bus_level, input signal_kind, input ready);
endinterface

interface lrlsc_csr_if;
   logic valid;
   logic ready;
   logic invert_receive;

   modport source  (output valid, output invert_receive, input ready);
   modport sink    (input valid, input invert_receive, output ready);
   modport monitor (input valid, input invert_receive, input ready);
endinterface

// File: rtl/lrlsc_run_stats.sv
// Run-length and sample statistics of the line classifier.
// Holds the level, run length and all counters; presents the next values of all but the long-run counter.
// Depends on lrlsc_pkg.
module lrlsc_run_stats import lrlsc_pkg::*; #(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
   parameter int RUN_WIDTH     = RUN_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stats_ctl_type            ctl,
   output logic [COUNTER_WIDTH-1:0] high_in,
   output logic [COUNTER_WIDTH-1:0] low_in,
   output logic [COUNTER_WIDTH-1:0] trans_in,
   output logic [COUNTER_WIDTH-1:0] short_in,
   output logic [COUNTER_WIDTH-1:0] medium_in,
   output logic [COUNTER_WIDTH-1:0] very_long_in
);

   localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);
   localparam logic [RUN_WIDTH-1:0]     RUN_ONE = RUN_WIDTH'(1);

   logic                     primed_ff, primed_in;
   logic                     prev_ff, prev_in;
   logic [RUN_WIDTH-1:0]     run_ff, run_in;
   logic [COUNTER_WIDTH-1:0] high_ff, low_ff, trans_ff;
   logic [COUNTER_WIDTH-1:0] short_ff, medium_ff, long_ff, very_long_ff;
   logic [COUNTER_WIDTH-1:0] long_in;

   always_comb begin
      primed_in    = primed_ff;
      prev_in      = prev_ff;
      run_in       = run_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      trans_in     = trans_ff;
      short_in     = short_ff;
      medium_in    = medium_ff;
      long_in      = long_ff;
      very_long_in = very_long_ff;
      if (ctl.step) begin
         if (!primed_ff) begin
            primed_in = 1'b1;
            prev_in   = ctl.level;
            run_in    = RUN_ONE;
         end else if (ctl.level == prev_ff) begin
            // hold at the top once saturated
            if (run_ff != '1) begin
               run_in = run_ff + RUN_ONE;
            end
         end else begin
            trans_in = trans_ff + CNT_ONE;
            priority if (run_ff <= RUN_WIDTH'(SHORT_LIMIT)) begin
               short_in = short_ff + CNT_ONE;
            end else if (run_ff <= RUN_WIDTH'(MEDIUM_LIMIT)) begin
               medium_in = medium_ff + CNT_ONE;
            end else if (run_ff <= RUN_WIDTH'(LONG_LIMIT)) begin
               long_in = long_ff + CNT_ONE;
            end else begin
               very_long_in = very_long_ff + CNT_ONE;
            end
            prev_in = ctl.level;
            run_in  = RUN_ONE;
         end
         if (ctl.level) begin
            high_in = high_ff + CNT_ONE;
         end else begin
            low_in = low_ff + CNT_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         prev_ff      <= 1'b1;
         run_ff       <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         trans_ff     <= '0;
         short_ff     <= '0;
         medium_ff    <= '0;
         long_ff      <= '0;
         very_long_ff <= '0;
      end else begin
         primed_ff    <= primed_in;
         prev_ff      <= prev_in;
         run_ff       <= run_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         trans_ff     <= trans_in;
         short_ff     <= short_in;
         medium_ff    <= medium_in;
         long_ff      <= long_in;
         very_long_ff <= very_long_in;
      end
   end

endmodule

// File: rtl/lrlsc_classify.sv
// Signal class decision of the line classifier.
// Pure logic on the updated counters; depends on lrlsc_pkg.
module lrlsc_classify import lrlsc_pkg::*; #(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  logic [COUNTER_WIDTH-1:0] high_cnt,
   input  logic [COUNTER_WIDTH-1:0] low_cnt,
   input  logic [COUNTER_WIDTH-1:0] trans_cnt,
   input  logic [COUNTER_WIDTH-1:0] short_cnt,
   input  logic [COUNTER_WIDTH-1:0] medium_cnt,
   input  logic [COUNTER_WIDTH-1:0] very_long_cnt,
   output kind_type                 kind
);

   logic [COUNTER_WIDTH-1:0] others;

   // sum wraps at the counter width
   assign others = short_cnt + very_long_cnt;

   always_comb begin
      priority if (low_cnt == '0 && high_cnt > COUNTER_WIDTH'(STUCK_LIMIT)) begin
         kind = KIND_STUCK_HIGH;
      end else if (high_cnt == '0 && low_cnt > COUNTER_WIDTH'(STUCK_LIMIT)) begin
         kind = KIND_STUCK_LOW;
      end else if (trans_cnt < COUNTER_WIDTH'(MIN_TRANSITIONS)) begin
         kind = KIND_UNKNOWN;
      end else if (medium_cnt > others) begin
         kind = KIND_MANCHESTER;
      end else if (short_cnt >= medium_cnt || very_long_cnt > medium_cnt) begin
         kind = KIND_SERIAL;
      end else begin
         kind = KIND_UNKNOWN;
      end
   end

endmodule

// File: rtl/line_run_length_signal_classifier_unit.sv
// Top level of the line run-length signal classifier.
// Sample register, statistics update, class decision and result register.
// Depends on lrlsc_pkg, lrlsc_if, lrlsc_run_stats and lrlsc_classify.
//
//   channel   | dir | payload                    | handshake
//   req_chan  | in  | raw_sample                 | valid/ready
//   rsp_chan  | out | bus_level, signal_kind     | valid/ready
//   csr_chan  | in  | invert_receive             | valid/ready, ready always high
//
// One beat per cycle sustained while rsp_chan is ready; a sample passes the sample
// register and then the result register before it is presented on rsp_chan.
// Counters update and the class is decided in the cycle the sample moves from
// the sample register into the result register.
// Synchronous reset clears the pipeline, statistics and the invert bit.
// A stalled result holds; the sample register still fills behind it.
module line_run_length_signal_classifier_unit import lrlsc_pkg::*; #(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
   parameter int RUN_WIDTH     = RUN_WIDTH_DEF
) (
   input logic          clock,
   input logic          reset,
   lrlsc_req_if.sink    req_chan,
   lrlsc_rsp_if.source  rsp_chan,
   lrlsc_csr_if.sink    csr_chan
);

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_level_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          bus_level_ff;
   kind_type      kind_ff;
   kind_type      kind;
   logic          invert_ff;
   logic          s1_move;
   logic          req_take;
   stats_ctl_type ctl;

   logic [COUNTER_WIDTH-1:0] high_in, low_in, trans_in;
   logic [COUNTER_WIDTH-1:0] short_in, medium_in, very_long_in;

   assign s1_move  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign csr_chan.ready = 1'b1;

   assign ctl.step  = s1_move;
   assign ctl.level = s1_level_ff;

   lrlsc_run_stats #(
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .RUN_WIDTH     (RUN_WIDTH)
   ) u_stats (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .high_in      (high_in),
      .low_in       (low_in),
      .trans_in     (trans_in),
      .short_in     (short_in),
      .medium_in    (medium_in),
      .very_long_in (very_long_in)
   );

   lrlsc_classify #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_classify (
      .high_cnt      (high_in),
      .low_cnt       (low_in),
      .trans_cnt     (trans_in),
      .short_cnt     (short_in),
      .medium_cnt    (medium_in),
      .very_long_cnt (very_long_in),
      .kind          (kind)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         invert_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            invert_ff <= csr_chan.invert_receive;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_level_ff <= req_chan.raw_sample;
      end
      if (s1_move) begin
         bus_level_ff <= s1_level_ff ^ invert_ff;
         kind_ff      <= kind;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bus_level   = bus_level_ff;
   assign rsp_chan.signal_kind = kind_ff;

endmodule

// File: rtl/lrlsc_checker.sv
// Port-level checks for the line run-length signal classifier.
// Watches the three channels' handshake and payload; bound to the top level below.
// Depends on lrlsc_pkg.
module lrlsc_checker import lrlsc_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input logic     rsp_bus_level,
   input kind_type rsp_signal_kind,
   input logic     csr_valid,
   input logic     csr_ready
);

   // a result never lingers across reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_bus_level) && $stable(rsp_signal_kind)))
      else $error("stalled result changed");

   // a fresh result comes from an accepted sample beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a sample");

   // only the five class codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_signal_kind <= KIND_SERIAL))
      else $error("bad signal class");

   // register writes are never back-pressured
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind line_run_length_signal_classifier_unit lrlsc_checker u_lrlsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_bus_level   (rsp_chan.bus_level),
   .rsp_signal_kind (rsp_chan.signal_kind),
   .csr_valid       (csr_chan.valid),
   .csr_ready       (csr_chan.ready)
);
